>>> src/sttbs_pkg.sv
// ============================================================================
// sttbs_pkg: shared types and constants of the sorted tag table
// Holds the opcode and status codes, the key layout, and the control bits
// of the search token that moves through the row of probe cells.
// ============================================================================
package sttbs_pkg;

    localparam int HALF_W  = 16;
    localparam int KEY_W   = 2 * HALF_W;
    localparam int INDEX_W = 10;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_SEARCH = 2'd2
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_CLEARED   = 3'd0,
        ST_APPENDED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic valid;
        logic done;
        logic found;
    } tok_t;

endpackage

>>> src/sorted_tag_table_binary_search.sv
// ============================================================================
// sorted_tag_table_binary_search: sorted key table with binary search
// Keeps up to TABLE_DEPTH keys and answers clear, append and search items
// with one result item each. The user must append the keys in ascending order.
// ============================================================================
// The block does not check the key order. One item is worked on at a time.
// A clear or append item passes through the hold state before the next
// acceptance. A search item runs through a row of $clog2(TABLE_DEPTH)+1
// probe cells, one probe per cycle, sharing one read port of the key table.
// A result item that is not taken at once keeps the next item in the hold
// state and so holds the acceptance after it back. The key is the group
// number in the upper half and the element number in the lower half.
// Opcode 3 acts as a search. The result index is the low 10 bits of the
// entry index.
module sorted_tag_table_binary_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // group_number[15:0], element_number[31:16]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // entry_index[9:0], zero fill[15:10]
    output logic [2:0]  m_tuser    // status[2:0]
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH+1);
    localparam int NCELL = AW + 1;
    localparam int KW    = sttbs_pkg::KEY_W;
    localparam int IW    = sttbs_pkg::INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_HOLD   = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    sttbs_pkg::status_t     res_stat_reg, res_stat_next;
    logic [AW-1:0]          res_idx_reg, res_idx_next;
    logic                   m_valid_reg, m_valid_next;
    sttbs_pkg::status_t     m_stat_reg, m_stat_next;
    logic [AW-1:0]          m_idx_reg, m_idx_next;
    sttbs_pkg::tok_t        inj_tok_reg, inj_tok_next;
    logic [CW-1:0]          inj_hix_reg;
    logic [KW-1:0]          inj_key_reg;

    sttbs_pkg::tok_t        tok [0:NCELL];
    logic [CW-1:0]          lo  [0:NCELL];
    logic [CW-1:0]          hix [0:NCELL];
    logic [AW-1:0]          idx [0:NCELL];
    logic [KW-1:0]          key [0:NCELL];
    logic                   cell_req  [0:NCELL-1];
    logic [AW-1:0]          cell_addr [0:NCELL-1];

    logic                   accept;
    logic                   out_free;
    logic [KW-1:0]          in_key;
    sttbs_pkg::opcode_t     in_op;
    logic                   wr_en;
    logic [AW-1:0]          rd_addr;
    logic [KW-1:0]          rd_data;
    logic [CW:0]            inj_sum;
    logic [AW+IW-1:0]       idx_ext;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign in_key   = {s_tdata[15:0], s_tdata[31:16]};
    assign in_op    = sttbs_pkg::opcode_t'(s_tuser);
    assign inj_sum  = {1'b0, count_reg} - {{CW{1'b0}}, 1'b1};

    assign tok[0] = inj_tok_reg;
    assign lo[0]  = '0;
    assign hix[0] = inj_hix_reg;
    assign idx[0] = '0;
    assign key[0] = inj_key_reg;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        sttbs_cell #(
            .TABLE_DEPTH(TABLE_DEPTH)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (tok[g]),
            .lo_in   (lo[g]),
            .hix_in  (hix[g]),
            .idx_in  (idx[g]),
            .key_in  (key[g]),
            .probe   (rd_data),
            .rd_req  (cell_req[g]),
            .rd_addr (cell_addr[g]),
            .tok_out (tok[g+1]),
            .lo_out  (lo[g+1]),
            .hix_out (hix[g+1]),
            .idx_out (idx[g+1]),
            .key_out (key[g+1])
        );
    end

    sttbs_key_mem #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (in_key),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        rd_addr = '0;
        if (accept) begin
            rd_addr = inj_sum[AW:1];
        end else begin
            for (int i = 0; i < NCELL; i++) begin
                rd_addr = rd_addr | (cell_req[i] ? cell_addr[i] : '0);
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        res_stat_next = res_stat_reg;
        res_idx_next  = res_idx_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_stat_next   = m_stat_reg;
        m_idx_next    = m_idx_reg;
        inj_tok_next  = '0;
        wr_en         = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (in_op)
                        sttbs_pkg::OP_CLEAR: begin
                            count_next    = '0;
                            res_stat_next = sttbs_pkg::ST_CLEARED;
                            res_idx_next  = '0;
                            state_next    = S_HOLD;
                        end
                        sttbs_pkg::OP_APPEND: begin
                            res_idx_next = '0;
                            if (count_reg >= CW'(TABLE_DEPTH)) begin
                                res_stat_next = sttbs_pkg::ST_FULL;
                            end else begin
                                wr_en         = 1'b1;
                                res_idx_next  = count_reg[AW-1:0];
                                count_next    = count_reg + {{(CW-1){1'b0}}, 1'b1};
                                res_stat_next = sttbs_pkg::ST_APPENDED;
                            end
                            state_next = S_HOLD;
                        end
                        default: begin
                            inj_tok_next.valid = 1'b1;
                            state_next         = S_SEARCH;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (tok[NCELL].valid) begin
                    if (tok[NCELL].found) begin
                        res_stat_next = sttbs_pkg::ST_FOUND;
                        res_idx_next  = idx[NCELL];
                    end else begin
                        res_stat_next = sttbs_pkg::ST_NOT_FOUND;
                        res_idx_next  = '0;
                    end
                    state_next = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_stat_next  = res_stat_reg;
                    m_idx_next   = res_idx_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            inj_tok_reg <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            inj_tok_reg <= inj_tok_next;
        end
        res_stat_reg <= res_stat_next;
        res_idx_reg  <= res_idx_next;
        m_stat_reg   <= m_stat_next;
        m_idx_reg    <= m_idx_next;
        inj_hix_reg  <= count_reg;
        inj_key_reg  <= in_key;
    end

    assign idx_ext  = {{IW{1'b0}}, m_idx_reg};
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_stat_reg;
    assign m_tdata  = {{(16-IW){1'b0}}, idx_ext[IW-1:0]};

endmodule

>>> src/sttbs_key_mem.sv
// ============================================================================
// sttbs_key_mem: key table storage
// One write port for appends and one read port with registered read data
// that serves the probe cells.
// ============================================================================
module sttbs_key_mem #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   wr_addr,
    input  logic [sttbs_pkg::KEY_W-1:0]      wr_data,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
    output logic [sttbs_pkg::KEY_W-1:0]      rd_data
);

    logic [sttbs_pkg::KEY_W-1:0] mem [0:TABLE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> src/sttbs_cell.sv
// ============================================================================
// sttbs_cell: one probe step of the binary search
// Compares the key with the entry read at the midpoint of its bounds,
// narrows the bounds, requests the next midpoint and passes the token on.
// ============================================================================
module sttbs_cell #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  sttbs_pkg::tok_t                      tok_in,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]     lo_in,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]     hix_in,
    input  logic [$clog2(TABLE_DEPTH)-1:0]       idx_in,
    input  logic [sttbs_pkg::KEY_W-1:0]          key_in,
    input  logic [sttbs_pkg::KEY_W-1:0]          probe,
    output logic                                 rd_req,
    output logic [$clog2(TABLE_DEPTH)-1:0]       rd_addr,
    output sttbs_pkg::tok_t                      tok_out,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]     lo_out,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]     hix_out,
    output logic [$clog2(TABLE_DEPTH)-1:0]       idx_out,
    output logic [sttbs_pkg::KEY_W-1:0]          key_out
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH+1);

    sttbs_pkg::tok_t tok_next;
    logic [CW-1:0]   lo_next;
    logic [CW-1:0]   hix_next;
    logic [AW-1:0]   idx_next;
    logic [CW:0]     mid_sum;
    logic [AW-1:0]   mid;
    logic [CW:0]     nxt_sum;
    logic            active;

    always_comb begin
        active   = tok_in.valid && !tok_in.done;
        mid_sum  = {1'b0, lo_in} + {1'b0, hix_in} - {{CW{1'b0}}, 1'b1};
        mid      = mid_sum[AW:1];
        tok_next = tok_in;
        lo_next  = lo_in;
        hix_next = hix_in;
        idx_next = idx_in;
        if (active) begin
            if (lo_in >= hix_in) begin
                tok_next.done  = 1'b1;
                tok_next.found = 1'b0;
            end else if (key_in == probe) begin
                tok_next.done  = 1'b1;
                tok_next.found = 1'b1;
                idx_next       = mid;
            end else if (key_in < probe) begin
                hix_next = CW'(mid);
            end else begin
                lo_next = CW'(mid) + {{(CW-1){1'b0}}, 1'b1};
            end
        end
        nxt_sum = {1'b0, lo_next} + {1'b0, hix_next} - {{CW{1'b0}}, 1'b1};
        rd_addr = nxt_sum[AW:1];
        rd_req  = active && !tok_next.done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_out <= '0;
        end else begin
            tok_out <= tok_next;
        end
        lo_out  <= lo_next;
        hix_out <= hix_next;
        idx_out <= idx_next;
        key_out <= key_in;
    end

endmodule
